// ===== sv/sfo_pkg.sv =====
// ----------------------------------------------------------------------------
// sfo_pkg
// Shared widths and reset constants for the spectral flux onset unit.
// ----------------------------------------------------------------------------
package sfo_pkg;

  localparam int MAG_W          = 24;    // bin magnitude, unsigned q16.8
  localparam int ACC_W          = 34;    // frame sums, unsigned q26.8
  localparam int CFG_W          = 11;    // frame_bins register
  localparam int MAX_BINS_DEF   = 1024;
  localparam int FRAME_BINS_RST = 1024;

endpackage

// ===== sv/sfo_ram.sv =====
// ----------------------------------------------------------------------------
// sfo_ram
// Generic simple dual-port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module sfo_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/spectral_flux_onset_unit.sv =====
// ----------------------------------------------------------------------------
// spectral_flux_onset_unit
// Spectral flux onset function: per-frame sums of absolute and rising bin
// differences against the previous frame, kept in a ram.
// ----------------------------------------------------------------------------
// Throughput: one bin item per clock cycle while the output is not stalled, set by the single read and the
//   single write port of the prior-magnitude ram, used once per item each.
// Output: the frame result is loaded into the output register when the last
//   bin of the frame leaves the read stage, which takes it at the accepting
//   edge; a stalled output holds that bin in the read stage.
// Reset: counters, sums and the fill count clear at once; bins not yet
//   written since reset read as zero through the fill count, no clear pass.
module spectral_flux_onset_unit
  import sfo_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_wr_en_i,
  input  logic [CFG_W-1:0] cfg_wr_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [MAG_W-1:0] magnitude_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ACC_W-1:0] flux_abs_o,
  output logic [ACC_W-1:0] flux_rising_o
);

  localparam int IDX_W   = $clog2(MAX_BINS);
  localparam int FILL_W  = $clog2(MAX_BINS + 1);
  localparam int RST_LEN = (FRAME_BINS_RST > MAX_BINS) ? MAX_BINS : FRAME_BINS_RST;

  typedef struct packed {
    logic             vld;
    logic             last;
    logic             known;
    logic [IDX_W-1:0] idx;
    logic [MAG_W-1:0] mag;
  } s1_t;

  // front end: bin counter and fill count
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  last_idx_q, last_idx_d;
  logic [IDX_W-1:0]  cfg_last;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              in_acc;
  logic              is_last;
  logic              is_known;

  // read stage
  s1_t               s1_q, s1_d;
  logic              s1_go;
  logic [MAG_W-1:0]  rd_data;
  logic [MAG_W-1:0]  prev;
  logic              fwd_vld_q, fwd_vld_d;
  logic [IDX_W-1:0]  fwd_idx_q, fwd_idx_d;
  logic [MAG_W-1:0]  fwd_mag_q, fwd_mag_d;
  logic              pos;
  logic [MAG_W-1:0]  abs_diff;
  logic [ACC_W:0]    abs_sum, rise_sum;
  logic [ACC_W-1:0]  abs_new, rise_new;
  logic [ACC_W-1:0]  abs_acc_q, abs_acc_d;
  logic [ACC_W-1:0]  rise_acc_q, rise_acc_d;

  // output register
  logic              out_vld_q, out_vld_d;
  logic [ACC_W-1:0]  out_abs_q, out_abs_d;
  logic [ACC_W-1:0]  out_rise_q, out_rise_d;

  // zero acts as one bin, oversize clips to the ram depth
  always_comb begin
    if (cfg_wr_data_i == '0) begin
      cfg_last = '0;
    end else if (32'(cfg_wr_data_i) > 32'(MAX_BINS)) begin
      cfg_last = IDX_W'(MAX_BINS - 1);
    end else begin
      cfg_last = IDX_W'(32'(cfg_wr_data_i) - 32'd1);
    end
  end

  assign s1_go      = s1_q.vld && (!s1_q.last || !out_vld_q || !out_stall_i);
  assign in_stall_o = s1_q.vld && !s1_go;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_last    = (idx_q == last_idx_q);
  // written bins always form a prefix from bin zero
  assign is_known   = (FILL_W'(idx_q) < fill_q);

  always_comb begin
    idx_d      = idx_q;
    last_idx_d = last_idx_q;
    fill_d     = fill_q;
    if (cfg_wr_en_i) begin
      idx_d      = '0;
      last_idx_d = cfg_last;
    end else if (in_acc) begin
      idx_d = is_last ? '0 : idx_q + 1'b1;
      if (!is_known) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_comb begin
    s1_d = s1_q;
    if (in_acc) begin
      s1_d.vld   = 1'b1;
      s1_d.last  = is_last;
      s1_d.known = is_known;
      s1_d.idx   = idx_q;
      s1_d.mag   = magnitude_i;
    end else if (s1_go) begin
      s1_d.vld = 1'b0;
    end
  end

  sfo_ram #(
    .WIDTH (MAG_W),
    .DEPTH (MAX_BINS)
  ) u_prior_ram (
    .clk_i     (clk_i),
    .wr_en_i   (s1_go),
    .wr_addr_i (s1_q.idx),
    .wr_data_i (s1_q.mag),
    .rd_en_i   (in_acc),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  // the latest write may have landed in the same cycle as this item's read
  always_comb begin
    if (fwd_vld_q && (fwd_idx_q == s1_q.idx)) begin
      prev = fwd_mag_q;
    end else if (s1_q.known) begin
      prev = rd_data;
    end else begin
      prev = '0;
    end
  end

  assign pos      = (s1_q.mag >= prev);
  assign abs_diff = pos ? (s1_q.mag - prev) : (prev - s1_q.mag);
  assign abs_sum  = {1'b0, abs_acc_q} + (ACC_W + 1)'(abs_diff);
  assign rise_sum = {1'b0, rise_acc_q} + (pos ? (ACC_W + 1)'(abs_diff) : '0);
  assign abs_new  = abs_sum[ACC_W] ? '1 : abs_sum[ACC_W-1:0];
  assign rise_new = rise_sum[ACC_W] ? '1 : rise_sum[ACC_W-1:0];

  always_comb begin
    fwd_vld_d  = fwd_vld_q;
    fwd_idx_d  = fwd_idx_q;
    fwd_mag_d  = fwd_mag_q;
    abs_acc_d  = abs_acc_q;
    rise_acc_d = rise_acc_q;
    out_abs_d  = out_abs_q;
    out_rise_d = out_rise_q;
    out_vld_d  = out_vld_q && out_stall_i;
    if (cfg_wr_en_i) begin
      abs_acc_d  = '0;
      rise_acc_d = '0;
    end else if (s1_go) begin
      fwd_vld_d = 1'b1;
      fwd_idx_d = s1_q.idx;
      fwd_mag_d = s1_q.mag;
      if (s1_q.last) begin
        out_vld_d  = 1'b1;
        out_abs_d  = abs_new;
        out_rise_d = rise_new;
        abs_acc_d  = '0;
        rise_acc_d = '0;
      end else begin
        abs_acc_d  = abs_new;
        rise_acc_d = rise_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      last_idx_q <= IDX_W'(RST_LEN - 1);
      fill_q     <= '0;
      s1_q       <= '0;
      fwd_vld_q  <= 1'b0;
      abs_acc_q  <= '0;
      rise_acc_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      idx_q      <= idx_d;
      last_idx_q <= last_idx_d;
      fill_q     <= fill_d;
      s1_q       <= s1_d;
      fwd_vld_q  <= fwd_vld_d;
      abs_acc_q  <= abs_acc_d;
      rise_acc_q <= rise_acc_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_idx_q  <= fwd_idx_d;
    fwd_mag_q  <= fwd_mag_d;
    out_abs_q  <= out_abs_d;
    out_rise_q <= out_rise_d;
  end

  assign out_valid_o   = out_vld_q;
  assign flux_abs_o    = out_abs_q;
  assign flux_rising_o = out_rise_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    FILL_W'(MAX_BINS) >= fill_q)
    else $error("fill count beyond ram depth");

  a_idx_in_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= last_idx_q)
    else $error("bin counter beyond frame end");

  a_idx_known : assert property (@(posedge clk_i) disable iff (!rst_ni)
    FILL_W'(idx_q) <= fill_q)
    else $error("bin counter skipped past written prefix");

  a_last_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_q.last && !cfg_wr_en_i |=> out_vld_q)
    else $error("frame end did not load output register");

  a_held_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.vld && !s1_go |=> s1_q.vld && $stable(s1_q.idx))
    else $error("held read stage item lost");

endmodule
